// ===== rtl/deadband_position_seeker_assert.svh =====
// Assertion macros for the deadband position seeker RTL.
`ifndef DEADBAND_POSITION_SEEKER_ASSERT_SVH
`define DEADBAND_POSITION_SEEKER_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define DBPS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define DBPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dbps_pkg.sv =====
// Package with codes, widths, reset values and types of the deadband position seeker.
package dbps_pkg;

   localparam int TargetWidth  = 13;
   localparam int SampleWidth  = 14;
   localparam int DeadbandWidth = 10;
   localparam int CompareWidth = 16;
   localparam int TicksWidth   = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   // Command codes.
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // Phase codes.
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_UP     = 2'd1;
   localparam logic [1:0] PH_DOWN   = 2'd2;
   localparam logic [1:0] PH_SETTLE = 2'd3;

   // Register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_DEADBAND = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_COMPARE  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SETTLE   = 2'd2;

   // Register reset values.
   localparam logic [DeadbandWidth-1:0] DEADBAND_RESET = 10'd90;
   localparam logic [CompareWidth-1:0]  COMPARE_RESET  = 16'd720;
   localparam logic [TicksWidth-1:0]    SETTLE_RESET   = 16'd150;

   typedef struct packed {
      logic [DeadbandWidth-1:0] deadband_mv;
      logic [CompareWidth-1:0]  drive_compare;
      logic [TicksWidth-1:0]    settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             phase;
      logic [TargetWidth-1:0] goal_mv;
      logic [TicksWidth-1:0]  settle_left;
   } state_type;

   typedef struct packed {
      logic [1:0]             cmd;
      logic [TargetWidth-1:0] target_mv;
      logic [SampleWidth-1:0] sample_mv;
   } item_type;

   typedef struct packed {
      logic                    drive_enable;
      logic                    drive_up;
      logic [CompareWidth-1:0] pwm_compare;
      logic                    serve_enable;
      logic                    motor_enable;
      logic                    busy_res;
      logic                    finished;
      logic                    start_ignored;
   } result_type;

endpackage

// ===== rtl/dbps_req_if.sv =====
// Request channel interface: command items with valid/ready handshake.
interface dbps_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [12:0]       target_mv;
   logic signed [13:0] sample_mv;

   modport source (output valid, output cmd, output target_mv, output sample_mv,
                   input ready);
   modport sink (input valid, input cmd, input target_mv, input sample_mv,
                 output ready);
endinterface

// ===== rtl/dbps_rsp_if.sv =====
// Response channel interface: controller status items with valid/ready handshake.
interface dbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_enable;
   logic        drive_up;
   logic [15:0] pwm_compare;
   logic        serve_enable;
   logic        motor_enable;
   logic        busy_res;
   logic        finished;
   logic        start_ignored;

   modport source (output valid, output drive_enable, output drive_up,
                   output pwm_compare, output serve_enable, output motor_enable,
                   output busy_res, output finished, output start_ignored,
                   input ready);
   modport sink (input valid, input drive_enable, input drive_up,
                 input pwm_compare, input serve_enable, input motor_enable,
                 input busy_res, input finished, input start_ignored,
                 output ready);
endinterface

// ===== rtl/deadband_position_seeker.sv =====
// Top level of the deadband position seeker: input register, controller state, result register.
//
// The block takes one command transaction per clock while rsp.ready lets the result
// register drain, set by the combinational state update between the input register and
// the result register, and returns exactly one status transaction for each, in order.
// A transaction is held in the input register and then in the result register, from
// which it appears on the response channel. req.ready falls only when both the input
// register and the result register hold transactions and rsp.ready is low. The user is
// to write the registers through the csr_ port only while the block is idle; the block
// does not enforce this. Writes take effect on the next transaction.
`include "deadband_position_seeker_assert.svh"

module deadband_position_seeker
   import dbps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   dbps_req_if.sink                 req,
   dbps_rsp_if.source               rsp,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type    cfg;
   item_type   in_item_ff;
   logic       in_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type res_in;
   result_type res_ff;
   logic       res_valid_ff;
   logic       advance;
   logic       req_fire;

   dbps_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   dbps_step u_step (
      .item       (in_item_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .result     (res_in)
   );

   // A held transaction moves into the result register when that register is free
   // or is being emptied in the same cycle.
   assign advance   = in_valid_ff && (!res_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            res_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp.ready) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.cmd       <= req.cmd;
         in_item_ff.target_mv <= req.target_mv;
         in_item_ff.sample_mv <= req.sample_mv;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid         = res_valid_ff;
   assign rsp.drive_enable  = res_ff.drive_enable;
   assign rsp.drive_up      = res_ff.drive_up;
   assign rsp.pwm_compare   = res_ff.pwm_compare;
   assign rsp.serve_enable  = res_ff.serve_enable;
   assign rsp.motor_enable  = res_ff.motor_enable;
   assign rsp.busy_res      = res_ff.busy_res;
   assign rsp.finished      = res_ff.finished;
   assign rsp.start_ignored = res_ff.start_ignored;

   `DBPS_ASSERT_SAME(a_settle_nonzero, state_ff.phase == PH_SETTLE, state_ff.settle_left != '0, "settling with no ticks left")
   `DBPS_ASSERT_NEXT(a_advance_fills, advance, res_valid_ff, "advanced transaction lost")
   `DBPS_ASSERT_SAME(a_ignored_busy, rsp.valid && rsp.start_ignored, rsp.busy_res && !rsp.finished, "ignored start while not busy")
   `DBPS_ASSERT_SAME(a_drive_outputs_off, rsp.valid && rsp.drive_enable, rsp.busy_res && !rsp.serve_enable && !rsp.motor_enable, "outputs enabled while driving")

endmodule

// ===== rtl/dbps_csr.sv =====
// Configuration registers of the deadband position seeker.
module dbps_csr
   import dbps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [CsrIndexWidth-1:0] wr_index,
   input  logic [CsrDataWidth-1:0]  wr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_DEADBAND: cfg_in.deadband_mv   = wr_data[DeadbandWidth-1:0];
            CSR_COMPARE:  cfg_in.drive_compare = wr_data[CompareWidth-1:0];
            CSR_SETTLE:   cfg_in.settle_ticks  = wr_data[TicksWidth-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_mv   <= DEADBAND_RESET;
         cfg_ff.drive_compare <= COMPARE_RESET;
         cfg_ff.settle_ticks  <= SETTLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/dbps_step.sv =====
// Next-state and result logic for one command item of the position seeker.
module dbps_step
   import dbps_pkg::*;
(
   input  item_type   item,
   input  state_type  state,
   input  cfg_type    cfg,
   output state_type  state_next,
   output result_type result
);

   logic signed [SampleWidth:0] sample_ext;
   logic signed [SampleWidth:0] target_ext;
   logic signed [SampleWidth:0] goal_ext;
   logic signed [SampleWidth:0] err;
   logic [SampleWidth:0]        mag;
   logic                        in_band;
   logic                        at_or_below_goal;
   logic                        at_or_above_goal;
   logic [TicksWidth-1:0]       left_dec;
   logic                        finished;
   logic                        ignored;
   logic                        driving;

   assign sample_ext = $signed({item.sample_mv[SampleWidth-1], item.sample_mv});
   assign target_ext = $signed({2'b00, item.target_mv});
   assign goal_ext   = $signed({2'b00, state.goal_mv});
   assign err        = sample_ext - target_ext;
   // The error spans -16383..8191, so its magnitude fits without overflow.
   assign mag        = err[SampleWidth] ? (SampleWidth+1)'(-err) : (SampleWidth+1)'(err);
   assign in_band    = mag <= {{(SampleWidth+1-DeadbandWidth){1'b0}}, cfg.deadband_mv};
   assign at_or_below_goal = sample_ext <= goal_ext;
   assign at_or_above_goal = sample_ext >= goal_ext;
   assign left_dec = (state.settle_left != '0) ? state.settle_left - 1'b1 : state.settle_left;

   always_comb begin
      state_next = state;
      finished   = 1'b0;
      ignored    = 1'b0;
      unique case (item.cmd)
         CMD_START: begin
            if (state.phase != PH_IDLE) begin
               ignored = 1'b1;
            end else begin
               state_next.goal_mv = item.target_mv;
               if (in_band) begin
                  finished = 1'b1;
               end else if (err > 0) begin
                  state_next.phase = PH_UP;
               end else begin
                  state_next.phase = PH_DOWN;
               end
            end
         end
         CMD_SAMPLE: begin
            // The drive stops on the first reading that reaches or crosses the goal.
            if ((state.phase == PH_UP && at_or_below_goal) ||
                (state.phase == PH_DOWN && at_or_above_goal)) begin
               state_next.settle_left = cfg.settle_ticks;
               if (cfg.settle_ticks == '0) begin
                  state_next.phase = PH_IDLE;
                  finished = 1'b1;
               end else begin
                  state_next.phase = PH_SETTLE;
               end
            end
         end
         CMD_TICK: begin
            if (state.phase == PH_SETTLE) begin
               state_next.settle_left = left_dec;
               if (left_dec == '0) begin
                  state_next.phase = PH_IDLE;
                  finished = 1'b1;
               end
            end
         end
         default: state_next = state;
      endcase
   end

   assign driving = (state_next.phase == PH_UP) || (state_next.phase == PH_DOWN);

   assign result.drive_enable  = driving;
   assign result.drive_up      = state_next.phase == PH_UP;
   assign result.pwm_compare   = driving ? cfg.drive_compare : '0;
   assign result.serve_enable  = state_next.phase == PH_IDLE;
   assign result.motor_enable  = state_next.phase == PH_IDLE;
   assign result.busy_res      = state_next.phase != PH_IDLE;
   assign result.finished      = finished;
   assign result.start_ignored = ignored;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the deadband position seeker: random and directed commands.
`timescale 1ns / 100ps

module testbench;
   import dbps_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED = 2'd3;
   localparam int SampleMin = -8192;
   localparam int SampleMax = 8191;
   localparam int TargetMax = 8191;

   // Predicts the status of every accepted command and checks the returned statuses in order.
   class seek_status_board;
      logic [DeadbandWidth-1:0] deadband_lim;
      logic [CompareWidth-1:0]  pwm_value;
      logic [TicksWidth-1:0]    settle_count;
      logic [1:0]               ctl_phase;
      logic [TargetWidth-1:0]   goal_mv;
      logic [TicksWidth-1:0]    ticks_left;
      result_type               status_due_q[$];
      int                       errors;
      int                       checked;

      function new();
         deadband_lim = DEADBAND_RESET;
         pwm_value    = COMPARE_RESET;
         settle_count = SETTLE_RESET;
         ctl_phase    = PH_IDLE;
         goal_mv      = '0;
         ticks_left   = '0;
         errors       = 0;
         checked      = 0;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_DEADBAND: deadband_lim = data[DeadbandWidth-1:0];
            CSR_COMPARE:  pwm_value = data[CompareWidth-1:0];
            CSR_SETTLE:   settle_count = data[TicksWidth-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return status_due_q.size();
      endfunction

      function void note_command(item_type it);
         result_type st;
         int s;
         int t;
         int g;
         int err;
         int lim;
         bit done;
         bit ignored;
         bit halt;
         bit driving;
         s = int'($signed(it.sample_mv));
         t = int'(it.target_mv);
         g = int'(goal_mv);
         lim = int'(deadband_lim);
         done = 1'b0;
         ignored = 1'b0;
         case (it.cmd)
            CMD_START: begin
               if (ctl_phase != PH_IDLE) begin
                  ignored = 1'b1;
               end else begin
                  goal_mv = it.target_mv;
                  err = s - t;
                  if ((err < 0 ? -err : err) <= lim) done = 1'b1;
                  else ctl_phase = (err > 0) ? PH_UP : PH_DOWN;
               end
            end
            CMD_SAMPLE: begin
               halt = (ctl_phase == PH_UP && s <= g) || (ctl_phase == PH_DOWN && s >= g);
               if (halt) begin
                  ticks_left = settle_count;
                  if (settle_count == 0) begin
                     ctl_phase = PH_IDLE;
                     done = 1'b1;
                  end else begin
                     ctl_phase = PH_SETTLE;
                  end
               end
            end
            CMD_TICK: begin
               if (ctl_phase == PH_SETTLE) begin
                  if (ticks_left != 0) ticks_left = ticks_left - 1'b1;
                  if (ticks_left == 0) begin
                     ctl_phase = PH_IDLE;
                     done = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         driving = (ctl_phase == PH_UP) || (ctl_phase == PH_DOWN);
         st.drive_enable  = driving;
         st.drive_up      = (ctl_phase == PH_UP);
         st.pwm_compare   = driving ? pwm_value : '0;
         st.serve_enable  = (ctl_phase == PH_IDLE);
         st.motor_enable  = (ctl_phase == PH_IDLE);
         st.busy_res      = (ctl_phase != PH_IDLE);
         st.finished      = done;
         st.start_ignored = ignored;
         status_due_q.push_back(st);
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] status %0d: %s", $time, checked, msg);
      endtask

      task check_status(result_type got);
         result_type want;
         if (status_due_q.size() == 0) begin
            report("status returned with no command outstanding");
         end else begin
            want = status_due_q.pop_front();
            if (got.drive_enable !== want.drive_enable)
               report($sformatf("drive_enable %b, want %b", got.drive_enable, want.drive_enable));
            if (got.drive_up !== want.drive_up)
               report($sformatf("drive_up %b, want %b", got.drive_up, want.drive_up));
            if (got.pwm_compare !== want.pwm_compare)
               report($sformatf("pwm_compare %0d, want %0d", got.pwm_compare, want.pwm_compare));
            if (got.serve_enable !== want.serve_enable)
               report($sformatf("serve_enable %b, want %b", got.serve_enable, want.serve_enable));
            if (got.motor_enable !== want.motor_enable)
               report($sformatf("motor_enable %b, want %b", got.motor_enable, want.motor_enable));
            if (got.busy_res !== want.busy_res)
               report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
            if (got.finished !== want.finished)
               report($sformatf("finished %b, want %b", got.finished, want.finished));
            if (got.start_ignored !== want.start_ignored)
               report($sformatf("start_ignored %b, want %b", got.start_ignored,
                                want.start_ignored));
         end
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   dbps_req_if req_ch();
   dbps_rsp_if rsp_ch();

   seek_status_board sb;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   bit long_hold_req = 1'b0;

   deadband_position_seeker u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic item_type mk(logic [1:0] c, int t, int s);
      item_type it;
      it.cmd = c;
      it.target_mv = t[TargetWidth-1:0];
      it.sample_mv = s[SampleWidth-1:0];
      return it;
   endfunction

   task automatic send_cmd(input item_type it);
      int gap;
      gap = req_calm ? 0 : $urandom_range(10);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= it.cmd;
      req_ch.target_mv <= it.target_mv;
      req_ch.sample_mv <= it.sample_mv;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_command(it);
   endtask

   // Stops offering commands until every status is back, then lets the pipeline empty.
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic set_regs(input logic [15:0] db_word, input logic [15:0] cmp,
                           input logic [15:0] ticks);
      write_reg(CSR_DEADBAND, db_word);
      write_reg(CSR_COMPARE, cmp);
      write_reg(CSR_SETTLE, ticks);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly well-formed seek sequences driven from the predicted phase, with some noise.
   task automatic run_random(input int n, input bit with_hold);
      item_type it;
      int k;
      int g;
      int d;
      int v;
      for (k = 0; k < n; k++) begin
         if (k == n / 2) wait_quiet();
         if (with_hold && k == 10) long_hold_req = 1'b1;
         g = int'(sb.goal_mv);
         d = int'(sb.deadband_lim);
         if ($urandom_range(9) < 2) begin
            it = mk(2'($urandom_range(3)), $urandom, $urandom);
         end else begin
            case (sb.ctl_phase)
               PH_IDLE: begin
                  it = mk(CMD_START, $urandom, $urandom);
                  if ($urandom_range(4) == 0) begin
                     v = int'(it.target_mv) + rand_between(-d - 2, d + 2);
                     if (v > SampleMax) v = SampleMax;
                     it.sample_mv = v[SampleWidth-1:0];
                  end
               end
               PH_UP: begin
                  if ($urandom_range(3) == 0 || g == TargetMax) begin
                     v = ($urandom_range(2) == 0) ? g : rand_between(SampleMin, g);
                  end else begin
                     v = rand_between(g + 1, SampleMax);
                  end
                  it = mk(CMD_SAMPLE, $urandom, v);
               end
               PH_DOWN: begin
                  if ($urandom_range(3) == 0) begin
                     v = ($urandom_range(2) == 0) ? g : rand_between(g, SampleMax);
                  end else begin
                     v = rand_between(SampleMin, g - 1);
                  end
                  it = mk(CMD_SAMPLE, $urandom, v);
               end
               default: it = mk(CMD_TICK, $urandom, $urandom);
            endcase
         end
         send_cmd(it);
      end
   endtask

   // Status sink: random stalls per transaction, plus one long hold on request.
   initial begin : status_sink
      result_type got;
      int wait_left;
      int hold_left;
      bit took;
      wait_left = 0;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         took = rsp_ch.valid && rsp_ch.ready;
         if (took) begin
            got.drive_enable  = rsp_ch.drive_enable;
            got.drive_up      = rsp_ch.drive_up;
            got.pwm_compare   = rsp_ch.pwm_compare;
            got.serve_enable  = rsp_ch.serve_enable;
            got.motor_enable  = rsp_ch.motor_enable;
            got.busy_res      = rsp_ch.busy_res;
            got.finished      = rsp_ch.finished;
            got.start_ignored = rsp_ch.start_ignored;
            sb.check_status(got);
            wait_left = rsp_calm ? 0 : $urandom_range(10);
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 64;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int ph;
      logic [15:0] db_word;
      logic [15:0] cmp;
      logic [15:0] ticks;
      sb = new();
      req_ch.valid     <= 1'b0;
      req_ch.cmd       <= CMD_TICK;
      req_ch.target_mv <= '0;
      req_ch.sample_mv <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: idle commands, deadband edge, a downward move and an ignored start.
      send_cmd(mk(CMD_UNUSED, 8191, -1));
      send_cmd(mk(CMD_SAMPLE, 0, 0));
      send_cmd(mk(CMD_TICK, 0, 0));
      send_cmd(mk(CMD_START, 1000, 1090));
      send_cmd(mk(CMD_START, 1000, 909));
      send_cmd(mk(CMD_START, 5, 5));
      send_cmd(mk(CMD_TICK, 0, 0));
      send_cmd(mk(CMD_SAMPLE, 0, 999));
      send_cmd(mk(CMD_UNUSED, 0, 0));
      wait_quiet();

      // Upper deadband bits must be dropped, leaving a zero deadband.
      set_regs(16'hFC00, 16'hFFFF, 16'd2);
      send_cmd(mk(CMD_SAMPLE, 0, 1000));
      send_cmd(mk(CMD_SAMPLE, 0, -8192));
      send_cmd(mk(CMD_START, 0, 8191));
      send_cmd(mk(CMD_TICK, 0, 0));
      send_cmd(mk(CMD_TICK, 0, 0));
      send_cmd(mk(CMD_START, 4000, 4001));
      send_cmd(mk(CMD_SAMPLE, 0, 4000));
      send_cmd(mk(CMD_TICK, 0, 0));
      send_cmd(mk(CMD_TICK, 0, 0));
      wait_quiet();

      // With no settle ticks the stopping sample completes the start itself.
      set_regs(16'h03FF, 16'd0, 16'd0);
      send_cmd(mk(CMD_START, 8191, -8192));
      send_cmd(mk(CMD_SAMPLE, 0, 8191));
      send_cmd(mk(CMD_START, 0, 8191));
      send_cmd(mk(CMD_SAMPLE, 0, -8192));
      send_cmd(mk(CMD_START, 0, 1023));
      send_cmd(mk(CMD_START, 0, -1024));
      send_cmd(mk(CMD_SAMPLE, 0, 0));
      wait_quiet();

      for (ph = 0; ph < 10; ph++) begin
         req_calm = ($urandom_range(3) == 0);
         rsp_calm = ($urandom_range(3) == 0);
         db_word = {6'($urandom), 10'($urandom_range(400))};
         if (ph % 4 == 0) db_word[9:0] = '0;
         if (ph % 4 == 1) db_word[9:0] = '1;
         cmp = 16'($urandom);
         if (ph == 1) cmp = '0;
         if (ph == 2) cmp = '1;
         ticks = 16'($urandom_range(4));
         if (ph == 5) ticks = '0;
         if (ph == 8) ticks = 16'($urandom_range(30, 10));
         if (ph == 4) write_reg(CSR_UNUSED, 16'($urandom));
         set_regs(db_word, cmp, ticks);
         run_random(145, ph == 3 || ph == 7);
         wait_quiet();
      end

      // Longest settle time: the run ends with the block still settling.
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      set_regs(16'd0, 16'd300, 16'hFFFF);
      send_cmd(mk(CMD_START, 100, 200));
      send_cmd(mk(CMD_SAMPLE, 0, 100));
      send_cmd(mk(CMD_TICK, 0, 0));
      send_cmd(mk(CMD_TICK, 0, 0));
      send_cmd(mk(CMD_SAMPLE, 0, 50));
      send_cmd(mk(CMD_START, 0, 0));
      send_cmd(mk(CMD_TICK, 0, 0));
      wait_quiet();
      repeat (8) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
